// ===== src/rds_pkg.sv =====
// Package for the room dispatch scheduler.
// Field widths, saturation limits, the per-room entry layout and the sequencer states.
// No dependencies.
package rds_pkg;

    localparam int START_W       = 32;
    localparam int TIME_W        = 48;
    localparam int COUNT_W       = 32;
    localparam int ROOM_W        = 4;
    localparam int CFG_W         = 5;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 56;
    localparam int MAX_ROOMS_DEF = 16;

    localparam logic [CFG_W-1:0]   ROOM_COUNT_RST = 5'd16;
    localparam logic [TIME_W-1:0]  TIME_MAX       = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [COUNT_W-1:0] use_count;
        logic [TIME_W-1:0]  free_until;
    } t_room_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// ===== src/room_dispatch_scheduler.sv =====
// Room dispatch scheduler: sequencer around one synchronous room table.
// Depends on rds_pkg.
//
// Usage:
//   Slave channel takes one booking word: tdata = start_time (lowest), end_time;
//   tlast = last_booking. Bookings are expected in ascending start order.
//   Master channel gives one result word per booking: tdata = assigned_room,
//   actual_begin, busiest_room; tlast = batch_done.
//   room_count is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// Steps:
//   Each booking goes through these steps, n being the rooms in use: take the
//   word, n reads of the room table (one port, one room a cycle), evaluate the
//   last read, then write back the chosen room.
//   The next booking is taken in the cycle after the write-back.
// Reset:
//   Synchronous, active low. All rooms read as free with zero use and
//   room_count returns to 16. The same clearing happens after a tlast booking,
//   through two valid flags per room (whole entry, free time).
// Stall:
//   A result waits in the output register while the next booking is taken and
//   scanned; write-back holds until the output register is free.
module room_dispatch_scheduler #(
    parameter int MAX_ROOMS = rds_pkg::MAX_ROOMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [rds_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // start_time [31:0], end_time [63:32]
    input  logic [rds_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // assigned_room [3:0], actual_begin [51:4], busiest_room [55:52]
    output logic [rds_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                         o_m_axis_tlast
);
    import rds_pkg::*;

    localparam int IW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_room_count;
    logic [START_W-1:0] r_start;
    logic [START_W-1:0] r_dur;
    logic               r_last;

    t_room_entry        r_mem [MAX_ROOMS];
    t_room_entry        r_q;
    logic [MAX_ROOMS-1:0] r_valid;
    logic [MAX_ROOMS-1:0] r_free_v;
    logic               r_q_v;
    logic               r_q_fv;

    logic [IW-1:0]      r_rd_addr;
    logic               r_chk;
    logic [IW-1:0]      r_chk_idx;

    logic               r_found;
    logic [IW-1:0]      r_sel_idx;
    logic [COUNT_W-1:0] r_sel_use;
    logic               r_min_any;
    logic [IW-1:0]      r_min_idx;
    logic [TIME_W-1:0]  r_min_free;
    logic [COUNT_W-1:0] r_min_use;
    logic [IW-1:0]      r_best_idx;
    logic [COUNT_W-1:0] r_best_use;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic               w_accept;
    logic               w_rd_en;
    logic               w_done;
    logic [IW-1:0]      w_last_idx;

    logic [TIME_W-1:0]  w_chk_free;
    logic [COUNT_W-1:0] w_chk_use;
    logic               w_chk_avail;

    logic [IW-1:0]      w_idx;
    logic [TIME_W-1:0]  w_begin;
    logic [COUNT_W-1:0] w_use;
    logic [TIME_W:0]    w_sum;
    t_room_entry        w_wr_entry;
    logic [IW-1:0]      w_busy;
    logic [ROOM_W-1:0]  w_busy_out;

    // rooms in use: zero counts as one, anything above capacity saturates
    always_comb begin
        priority if (r_room_count == '0) begin
            w_last_idx = '0;
        end else if (int'(r_room_count) > MAX_ROOMS) begin
            w_last_idx = IW'(MAX_ROOMS - 1);
        end else begin
            w_last_idx = IW'(r_room_count - 1'b1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_SCAN;
            S_SCAN:  if (r_rd_addr == w_last_idx) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (!r_out_valid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_rd_en         = 1'b0;
        w_done          = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_SCAN:  w_rd_en = 1'b1;
            S_DRAIN: ;
            S_DONE:  w_done = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // entry under check: a released or cleared free time reads as zero,
    // a cleared entry reads with zero use
    assign w_chk_free  = r_q_fv ? r_q.free_until : '0;
    assign w_chk_use   = r_q_v ? r_q.use_count : '0;
    assign w_chk_avail = w_chk_free <= {{(TIME_W-START_W){1'b0}}, r_start};

    // write-back of the chosen room
    always_comb begin
        if (r_found) begin
            w_idx   = r_sel_idx;
            w_begin = {{(TIME_W-START_W){1'b0}}, r_start};
            w_use   = r_sel_use;
        end else begin
            w_idx   = r_min_idx;
            w_begin = r_min_free;
            w_use   = r_min_use;
        end
        w_sum = {1'b0, w_begin} + {{(TIME_W+1-START_W){1'b0}}, r_dur};
        w_wr_entry.free_until = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
        w_wr_entry.use_count  = (w_use == COUNT_MAX) ? w_use : w_use + 1'b1;
        // best so far was taken before the increment; only the chosen room moves
        if (w_wr_entry.use_count > r_best_use
            || (w_wr_entry.use_count == r_best_use && w_idx < r_best_idx)) begin
            w_busy = w_idx;
        end else begin
            w_busy = r_best_idx;
        end
        w_busy_out = r_last ? ROOM_W'(w_busy) : '0;
    end

    // room table
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_mem[w_idx] <= w_wr_entry;
        end
        if (w_rd_en) begin
            r_q <= r_mem[r_rd_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_room_count <= ROOM_COUNT_RST;
            r_valid      <= '0;
            r_free_v     <= '0;
            r_chk        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= w_rd_en;
            if (i_cfg_wr_en) begin
                r_room_count <= i_cfg_wr_data;
            end
            if (r_chk && w_chk_avail) begin
                r_free_v[r_chk_idx] <= 1'b0;  // release, use count kept
            end
            if (w_done) begin
                if (r_last) begin
                    r_valid  <= '0;
                    r_free_v <= '0;
                end else begin
                    r_valid[w_idx]  <= 1'b1;
                    r_free_v[w_idx] <= 1'b1;
                end
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start   <= i_s_axis_tdata[START_W-1:0];
            r_dur     <= (i_s_axis_tdata[2*START_W-1:START_W] > i_s_axis_tdata[START_W-1:0])
                       ? i_s_axis_tdata[2*START_W-1:START_W] - i_s_axis_tdata[START_W-1:0]
                       : '0;
            r_last    <= i_s_axis_tlast;
            r_rd_addr <= '0;
            r_found   <= 1'b0;
            r_min_any <= 1'b0;
        end else if (w_rd_en) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (w_rd_en) begin
            r_q_v     <= r_valid[r_rd_addr];
            r_q_fv    <= r_free_v[r_rd_addr];
            r_chk_idx <= r_rd_addr;
        end
        if (r_chk) begin
            if (w_chk_avail && !r_found) begin
                r_found   <= 1'b1;
                r_sel_idx <= r_chk_idx;
                r_sel_use <= w_chk_use;
            end
            if (!w_chk_avail && (!r_min_any || w_chk_free < r_min_free)) begin
                r_min_any  <= 1'b1;
                r_min_idx  <= r_chk_idx;
                r_min_free <= w_chk_free;
                r_min_use  <= w_chk_use;
            end
            if (r_chk_idx == '0 || w_chk_use > r_best_use) begin
                r_best_idx <= r_chk_idx;
                r_best_use <= w_chk_use;
            end
        end
        if (w_done) begin
            r_out_data <= {w_busy_out, w_begin, ROOM_W'(w_idx)};
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // a closing booking leaves every room free
    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_last) |=> (r_valid == '0 && r_free_v == '0))
        else $error("room table not cleared after batch end");

    // with no free room the earliest-freeing room must have been recorded
    a_min_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !r_found) |-> r_min_any)
        else $error("no room chosen at write-back");

    // the chosen room lies within the rooms in use
    a_room_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (w_idx <= w_last_idx))
        else $error("room outside the rooms in use");

    // a new word always starts its scan at room zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN && r_rd_addr == '0))
        else $error("scan did not start at room zero");

endmodule

// ===== tb/tb_room_dispatch_scheduler.sv =====
// Self-checking testbench for room_dispatch_scheduler: directed and random bookings,
// with an in-bench predictor of the room table. Depends on rds_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_room_dispatch_scheduler;

    import rds_pkg::*;

    localparam int STUCK_LIMIT   = 4000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int HOLD_OFF_AT   = 150;
    localparam int REPORT_MAX    = 10;
    localparam int CHAIN_LEN     = 20;

    typedef struct {
        logic [START_W-1:0] req_start;
        logic [START_W-1:0] req_end;
        logic               closes_batch;
    } t_booking;

    typedef struct {
        logic [ROOM_W-1:0] room;
        logic [TIME_W-1:0] begin_at;
        logic              batch_done;
        logic [ROOM_W-1:0] busiest;
    } t_dispatch;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wr_data   = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tlast  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    room_dispatch_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // predictor state
    logic [TIME_W-1:0]  room_free_at [MAX_ROOMS_DEF];
    logic [COUNT_W-1:0] room_uses    [MAX_ROOMS_DEF];
    logic [CFG_W-1:0]   room_count_cfg;

    t_booking    pending_bookings[$];
    t_dispatch   expected_results[$];
    int unsigned bookings_queued = 0;
    int unsigned bookings_taken  = 0;
    int unsigned fail_count      = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned hold_left       = 0;
    bit          hold_done       = 1'b0;
    int unsigned stuck_cycles    = 0;

    // random batch tracking, kept across phases so a batch may span a register write
    int unsigned      batch_left  = 0;
    logic [START_W-1:0] batch_clock = '0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_rooms();
        for (int r = 0; r < MAX_ROOMS_DEF; r++) begin
            room_free_at[r] = '0;
            room_uses[r]    = '0;
        end
    endfunction

    function automatic t_dispatch place_booking(logic [START_W-1:0] req_start,
                                                logic [START_W-1:0] req_end,
                                                logic closes_batch);
        t_dispatch         res;
        int                rooms_active;
        int                idx;
        int                best;
        bit                found;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] begin_at;

        if (room_count_cfg == 0)
            rooms_active = 1;
        else if (room_count_cfg > MAX_ROOMS_DEF)
            rooms_active = MAX_ROOMS_DEF;
        else
            rooms_active = int'(room_count_cfg);
        dur = (req_end > req_start) ? TIME_W'(req_end - req_start) : '0;

        for (int r = 0; r < rooms_active; r++)
            if (room_free_at[r] <= TIME_W'(req_start))
                room_free_at[r] = '0;

        found = 1'b0;
        idx   = 0;
        for (int r = 0; r < rooms_active; r++)
            if (!found && room_free_at[r] == '0) begin
                idx   = r;
                found = 1'b1;
            end

        if (found) begin
            begin_at = TIME_W'(req_start);
        end else begin
            // all busy: earliest to free, lower index wins ties
            idx = 0;
            for (int r = 1; r < rooms_active; r++)
                if (room_free_at[r] < room_free_at[idx])
                    idx = r;
            begin_at = room_free_at[idx];
        end

        room_free_at[idx] = (TIME_MAX - begin_at < dur) ? TIME_MAX : begin_at + dur;
        if (room_uses[idx] != COUNT_MAX)
            room_uses[idx] = room_uses[idx] + 1'b1;

        res.room       = ROOM_W'(idx);
        res.begin_at   = begin_at;
        res.batch_done = closes_batch;
        res.busiest    = '0;
        if (closes_batch) begin
            best = 0;
            for (int r = 1; r < rooms_active; r++)
                if (room_uses[r] > room_uses[best])
                    best = r;
            res.busiest = ROOM_W'(best);
            clear_rooms();
        end
        return res;
    endfunction

    task automatic queue_booking(logic [START_W-1:0] req_start, logic [START_W-1:0] req_end,
                                 logic closes_batch);
        t_booking b;
        b.req_start    = req_start;
        b.req_end      = req_end;
        b.closes_batch = closes_batch;
        pending_bookings.push_back(b);
        bookings_queued++;
    endtask

    // bursts of ascending bookings with short durations so rooms run out;
    // three in twenty are malformed (end not after start, or a wild or maximal end)
    task automatic queue_random_bookings(int unsigned count, bit close_at_end);
        logic [START_W:0]   t;
        logic [START_W-1:0] req_end;
        for (int unsigned k = 0; k < count; k++) begin
            if (batch_left == 0) begin
                batch_left  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
                batch_clock = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 5000);
            end
            t = batch_clock + $urandom_range(0, 3);
            batch_clock = t[START_W] ? '1 : t[START_W-1:0];
            case ($urandom_range(0, 19))
                0: req_end = batch_clock - $urandom_range(0, 2);
                1: req_end = $urandom;
                2: req_end = '1;
                default: begin
                    t = batch_clock + $urandom_range(1, 80);
                    req_end = t[START_W] ? '1 : t[START_W-1:0];
                end
            endcase
            batch_left--;
            if (close_at_end && k == count - 1)
                batch_left = 0;
            queue_booking(batch_clock, req_end, batch_left == 0);
        end
    endtask

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (bookings_taken != bookings_queued || expected_results.size() != 0);
    endtask

    task automatic write_room_count(logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // sender
    always @(posedge i_clk) begin
        t_booking b;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_bookings.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                b = pending_bookings.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {b.req_end, b.req_start};
                i_s_axis_tlast  <= b.closes_batch;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (!hold_done && bookings_taken >= HOLD_OFF_AT) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= HOLD_OFF_LEN;
            hold_done       <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_dispatch want;
        t_dispatch got;
        if (!i_rst_n) begin
            clear_rooms();
            room_count_cfg = ROOM_COUNT_RST;
        end else begin
            if (i_cfg_wr_en)
                room_count_cfg = i_cfg_wr_data;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.room       = o_m_axis_tdata[ROOM_W-1:0];
                got.begin_at   = o_m_axis_tdata[ROOM_W +: TIME_W];
                got.batch_done = o_m_axis_tlast;
                got.busiest    = o_m_axis_tdata[ROOM_W+TIME_W +: ROOM_W];
                if (expected_results.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected result word %h last %b", o_m_axis_tdata,
                                 o_m_axis_tlast);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.room !== want.room || got.begin_at !== want.begin_at ||
                        got.batch_done !== want.batch_done || got.busiest !== want.busiest) begin
                        if (fail_count < REPORT_MAX)
                            $display("mismatch: expected room %0d begin %h done %b busiest %0d",
                                     want.room, want.begin_at, want.batch_done, want.busiest,
                                     ", got room %0d begin %h done %b busiest %0d",
                                     got.room, got.begin_at, got.batch_done, got.busiest);
                        fail_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(place_booking(i_s_axis_tdata[START_W-1:0],
                                                         i_s_axis_tdata[IN_DATA_W-1:START_W],
                                                         i_s_axis_tlast));
                bookings_taken <= bookings_taken + 1;
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 85;

        // two rooms: delays, zero and negative durations
        write_room_count(5'd2);
        queue_booking(32'd0, 32'd10, 1'b0);
        queue_booking(32'd0, 32'd0, 1'b0);
        queue_booking(32'd1, 32'd5, 1'b0);
        queue_booking(32'd2, 32'd4, 1'b0);
        queue_booking(32'd3, 32'd1, 1'b0);
        queue_booking(32'd6, 32'd8, 1'b0);
        queue_booking(32'd10, 32'd20, 1'b1);
        // equal use: busiest goes to the lower room
        queue_booking(32'd100, 32'd200, 1'b0);
        queue_booking(32'd100, 32'd300, 1'b1);
        queue_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_booking(32'hFFFF_FFFF, 32'd0, 1'b1);
        wait_for_drain();

        // zero rooms reads as one; batch left open across the next write
        write_room_count(5'd0);
        queue_booking(32'd0, 32'hFFFF_FFFF, 1'b0);
        queue_booking(32'd5, 32'hFFFF_FFFF, 1'b0);
        queue_booking(32'd6, 32'd7, 1'b0);
        wait_for_drain();
        write_room_count(5'd31);
        queue_booking(32'd7, 32'd9, 1'b0);
        queue_booking(32'd7, 32'd8, 1'b0);
        queue_booking(32'd9, 32'd10, 1'b0);
        queue_booking(32'd9, 32'h1234_5678, 1'b1);
        wait_for_drain();

        write_room_count(5'($urandom_range(2, 15)));
        queue_random_bookings(222, 1'b0);
        wait_for_drain();
        write_room_count(5'd16);
        queue_random_bookings(222, 1'b0);
        wait_for_drain();

        send_idle_pct = 85;
        recv_idle_pct = 38;
        write_room_count(5'd17);
        queue_random_bookings(148, 1'b0);
        wait_for_drain();
        write_room_count(5'd1);
        queue_random_bookings(148, 1'b0);
        wait_for_drain();
        write_room_count(5'($urandom_range(2, 15)));
        queue_random_bookings(148, 1'b0);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_room_count(5'd31);
        queue_random_bookings(148, 1'b0);
        wait_for_drain();
        write_room_count(5'd0);
        queue_random_bookings(148, 1'b0);
        wait_for_drain();
        write_room_count(5'($urandom_range(2, 15)));
        queue_random_bookings(148, 1'b1);
        wait_for_drain();

        // one room, maximal durations chained so the free time grows past 32 bits
        write_room_count(5'd1);
        for (int k = 0; k < CHAIN_LEN; k++)
            queue_booking(32'd0, 32'hFFFF_FFFF, k == CHAIN_LEN - 1);
        wait_for_drain();

        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
